// ===== hdl/lpmd_pkg.sv =====
// Shared types and constants for the length-prefixed message deframer.
// No dependencies; every other file imports this package.
package lpmd_pkg;

  // Header size in bytes; the first two header bytes carry the total length.
  localparam int unsigned HEADER_BYTES = 4;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic        REG_PKT_MODE = 1'b0;

  // One delivered result.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       aborted;
    logic       corrupt;
  } result_t;

  // Everything one input byte causes: one or two results.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

  // Queue status seen by the input handshake and the back part.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/lpmd_front.sv =====
// Front part: accepts stream bytes, tracks the framing state and turns
// each byte into a queue entry of zero, one or two results. Uses lpmd_pkg.
module lpmd_front
  import lpmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       packet_mode,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       end_of_chunk,
  output logic       push,
  output entry_t     entry
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] msg_len_r, msg_len_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        err_r, err_nxt;

  // Framing decisions for the byte currently offered.
  always_comb begin
    logic        purge;
    logic [1:0]  n;
    logic [15:0] len;
    logic [15:0] cnt_inc;
    logic        skip_abort;
    purge          = end_of_chunk & packet_mode;
    n              = 2'd0;
    len            = {held_r, data_byte};
    cnt_inc        = byte_count_r + 16'd1;
    skip_abort     = 1'b0;
    byte_count_nxt = byte_count_r;
    msg_len_nxt    = msg_len_r;
    held_nxt       = held_r;
    err_nxt        = err_r;
    entry          = '0;

    priority if (err_r) begin
      // Latched error: bytes are dropped, a packet-mode chunk end clears it.
      if (purge) err_nxt = 1'b0;
      skip_abort = 1'b1;
    end else if (byte_count_r == 16'd0) begin
      held_nxt       = data_byte;
      byte_count_nxt = 16'd1;
    end else if (byte_count_r == 16'd1) begin
      msg_len_nxt = len;
      if (len < 16'(HEADER_BYTES)) begin
        // Declared length shorter than the header.
        err_nxt             = ~purge;
        byte_count_nxt      = 16'd0;
        entry.res0.corrupt  = 1'b1;
        n                   = 2'd1;
        skip_abort          = 1'b1;
      end else begin
        entry.two        = 1'b1;
        entry.res0.data  = held_r;
        entry.res0.first = 1'b1;
        entry.res1.data  = data_byte;
        entry.res1.last  = (len <= 16'd2);
        byte_count_nxt   = (len <= 16'd2) ? 16'd0 : 16'd2;
        n                = 2'd2;
      end
    end else begin
      entry.res0.data = data_byte;
      entry.res0.last = (cnt_inc >= msg_len_r);
      byte_count_nxt  = (cnt_inc >= msg_len_r) ? 16'd0 : cnt_inc;
      n               = 2'd1;
    end

    // Packet mode drops a message still partial at the chunk end.
    if (!skip_abort && purge && byte_count_nxt != 16'd0) begin
      byte_count_nxt = 16'd0;
      if (n == 2'd2) begin
        entry.res1.aborted = 1'b1;
      end else begin
        entry.res0.aborted = 1'b1;
        n                  = 2'd1;
      end
    end

    push = fire & (n != 2'd0);
  end

  // Framing state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      msg_len_r    <= '0;
      held_r       <= '0;
      err_r        <= 1'b0;
    end else if (fire) begin
      byte_count_r <= byte_count_nxt;
      msg_len_r    <= msg_len_nxt;
      held_r       <= held_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

// ===== hdl/lpmd_queue.sv =====
// Short queue of result entries between the front and back parts.
// Uses lpmd_pkg for the entry type and depth.
module lpmd_queue
  import lpmd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  entry_t            slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head         = slots_r[rptr_r];
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) slots_r[wptr_r] <= push_entry;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QPTR_W'(1);
      if (pop)  rptr_r <= rptr_r + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/lpmd_back.sv =====
// Back part: unpacks queue entries into single results and holds each one
// in the output register until it is taken. Uses lpmd_pkg.
module lpmd_back
  import lpmd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  entry_t        head,
  input  queue_status_t status,
  output logic          pop,
  input  logic          out_ready,
  output logic          out_valid,
  output result_t       out_res
);

  logic    valid_r;
  logic    idx_r, idx_nxt;
  logic    load;
  result_t res_r;

  // Load a new result whenever the queue holds an entry and the output register is free or being taken.
  always_comb begin
    load    = !status.empty && (!valid_r || out_ready);
    pop     = load && (idx_r || !head.two);
    idx_nxt = idx_r;
    if (load) idx_nxt = !pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load)           valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) res_r <= idx_r ? head.res1 : head.res0;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/length_prefixed_message_deframer_core.sv =====
// Top level of the length-prefixed message deframer: configuration port,
// front part, queue and back part. Uses lpmd_pkg and the lpmd_* modules.
//
// The block takes one stream byte per clock while in_ready is high and
// splits the stream into messages whose header opens with a 16-bit
// big-endian total length. For each accepted byte the front part updates the
// framing state and queues zero, one or two results; the back part delivers
// one result per cycle through an output register, so one byte per clock is
// sustained, limited by out_ready and by the single result port when a
// message's second byte yields two results. The queue between the two parts
// holds four entries; in_ready drops only when it is full. The packet_mode
// register sits at byte address 0 and should be written while idle.
module length_prefixed_message_deframer_core
  import lpmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_chunk,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_out_byte,
  output logic                  out_first_of_message,
  output logic                  out_last_of_message,
  output logic                  out_aborted,
  output logic                  out_stream_corrupt
);

  logic          pkt_mode_r;
  logic          reg_idx;
  logic          fire;
  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        head;
  queue_status_t status;
  result_t       out_res;

  // Configuration register.
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx == REG_PKT_MODE) ? CFG_DATA_W'(pkt_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_idx == REG_PKT_MODE) begin
      pkt_mode_r <= cfg_pwdata[0];
    end
  end

  // Input handshake.
  assign in_ready = !status.full;
  assign fire     = in_valid && in_ready;

  lpmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .packet_mode  (pkt_mode_r),
    .fire         (fire),
    .data_byte    (in_data_byte),
    .end_of_chunk (in_end_of_chunk),
    .push         (push),
    .entry        (push_entry)
  );

  lpmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  lpmd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_out_byte         = out_res.data;
  assign out_first_of_message = out_res.first;
  assign out_last_of_message  = out_res.last;
  assign out_aborted          = out_res.aborted;
  assign out_stream_corrupt   = out_res.corrupt;

endmodule
